// ----- src/pwarp_pkg.sv -----
// ----------------------------------------------------------------------------
// pwarp_pkg
// shared types, breakpoint tables and reciprocal constants for the point warp
// ----------------------------------------------------------------------------
package pwarp_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 8;
	localparam int SIZE_W    = 16;
	localparam int SIZE_Z_W  = 15;
	localparam int NUM_BP    = 6;
	localparam int NUM_AXES  = 3;
	localparam int NUM_KINDS = 2;

	// datapath widths
	localparam int T_W      = 18;                       // target in half units
	localparam int DT_W     = 17;                       // target step, in bounds always positive
	localparam int D_W      = 21;                       // offset into a segment, q.8
	localparam int SPAN_W   = 14;
	localparam int HSPAN_W  = 12;
	localparam int PROD1_W  = DT_W + D_W;
	localparam int NUM_W    = PROD1_W + FRAC_BITS - 1;
	localparam int X_W      = 40;
	localparam int XL_W     = 20;
	localparam int RECIP_W  = 46;
	localparam int RL_W     = 23;
	localparam int RECIP_SH = 47;
	localparam int PP_W     = 43;
	localparam int FULL_W   = X_W + RECIP_W;
	localparam int SUM_W    = 42;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic [SIZE_Z_W-1:0]       size_z_t;
	typedef logic [1:0]                axis_t;
	typedef logic [1:0]                reg_idx_t;
	typedef logic [2:0]                idx_t;
	typedef logic [3:0]                shift_t;
	typedef logic [RECIP_W-1:0]        recip_t;
	typedef logic signed [T_W-1:0]     half_t;
	typedef logic signed [12:0]        bp_t;
	typedef logic signed [2:0]         mul_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// per-stage load enables, handed from the top level to every lane
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	localparam reg_idx_t REG_ROOM_KIND = 2'd0;
	localparam reg_idx_t REG_SIZE_X    = 2'd1;
	localparam reg_idx_t REG_SIZE_Y    = 2'd2;
	localparam reg_idx_t REG_SIZE_Z    = 2'd3;

	localparam logic    RST_ROOM_KIND = 1'b0;
	localparam size_t   RST_SIZE_X    = 16'd2560;
	localparam size_t   RST_SIZE_Y    = 16'd2560;
	localparam size_z_t RST_SIZE_Z    = 15'd2048;

	localparam sum_t SAT_HI = (SUM_W'(1) <<< (COORD_W - 1)) - SUM_W'(1);
	localparam sum_t SAT_LO = -(SUM_W'(1) <<< (COORD_W - 1));

	// source breakpoints in map units, [kind][axis][index]
	localparam bp_t SRC_BP [NUM_KINDS][NUM_AXES][NUM_BP] = '{
		'{ '{-1280, -1248, -160, 160, 1248, 1280},
		   '{-1280, -1248, -160, 160, 1248, 1280},
		   '{0, 256, 2016, 2048, 0, 0} },
		'{ '{-2560, -2464, -320, 320, 2464, 2560},
		   '{-1280, -1152, 3712, 3840, 0, 0},
		   '{0, 352, 3328, 3392, 0, 0} }
	};

	localparam idx_t BP_COUNT [NUM_KINDS][NUM_AXES] = '{
		'{3'd6, 3'd6, 3'd4},
		'{3'd6, 3'd4, 3'd4}
	};

	// target in half units = mul * size + add
	localparam mul_t TGT_MUL [NUM_KINDS][NUM_AXES][NUM_BP] = '{
		'{ '{-1, -1, 0, 0, 1, 1},
		   '{-1, -1, 0, 0, 1, 1},
		   '{0, 0, 2, 2, 0, 0} },
		'{ '{-1, -1, 0, 0, 1, 1},
		   '{-1, -1, 1, 1, 0, 0},
		   '{0, 0, 2, 2, 0, 0} }
	};

	localparam bp_t TGT_ADD [NUM_KINDS][NUM_AXES][NUM_BP] = '{
		'{ '{0, 64, -320, 320, -64, 0},
		   '{0, 64, -320, 320, -64, 0},
		   '{0, 512, -64, 0, 0, 0} },
		'{ '{0, 192, -640, 640, -192, 0},
		   '{2560, 2816, 2304, 2560, 0, 0},
		   '{0, 704, -128, 0, 0, 0} }
	};

	// segment span = 2**shift * odd; reciprocal = ceil(2**47 / odd), zero for odd == 1
	localparam recip_t RECIP_3  = 46'd46912496118443;
	localparam recip_t RECIP_5  = 46'd28147497671066;
	localparam recip_t RECIP_11 = 46'd12794317123212;
	localparam recip_t RECIP_17 = 46'd8278675785608;
	localparam recip_t RECIP_19 = 46'd7407236229228;
	localparam recip_t RECIP_55 = 46'd2558863424643;
	localparam recip_t RECIP_67 = 46'd2100559527692;
	localparam recip_t RECIP_93 = 46'd1513306326402;

	// indexed by the upper breakpoint of a segment
	localparam shift_t SEG_SHIFT [NUM_KINDS][NUM_AXES][NUM_BP] = '{
		'{ '{0, 5, 6, 6, 6, 5},
		   '{0, 5, 6, 6, 6, 5},
		   '{0, 8, 5, 5, 0, 0} },
		'{ '{0, 5, 5, 7, 5, 5},
		   '{0, 7, 8, 7, 0, 0},
		   '{0, 5, 5, 6, 0, 0} }
	};

	localparam recip_t SEG_RECIP [NUM_KINDS][NUM_AXES][NUM_BP] = '{
		'{ '{'0, '0, RECIP_17, RECIP_5, RECIP_17, '0},
		   '{'0, '0, RECIP_17, RECIP_5, RECIP_17, '0},
		   '{'0, '0, RECIP_55, '0, '0, '0} },
		'{ '{'0, RECIP_3, RECIP_67, RECIP_5, RECIP_67, RECIP_3},
		   '{'0, '0, RECIP_19, '0, '0, '0},
		   '{'0, RECIP_11, RECIP_93, '0, '0, '0} }
	};

	localparam size_t SIZE_MIN [NUM_KINDS][NUM_AXES] = '{
		'{16'd416, 16'd416, 16'd304},
		'{16'd864, 16'd272, 16'd432}
	};

	localparam size_t SIZE_MAX [NUM_KINDS][NUM_AXES] = '{
		'{16'd65406, 16'd65406, 16'd32767},
		'{16'd65342, 16'd62846, 16'd32767}
	};

	// target breakpoint in half map units
	function automatic half_t tgt_half(mul_t mul, bp_t add, size_t size);
		half_t sz;
		half_t t;
		sz = signed'(T_W'(size));
		case (mul)
			-3'sd1: t = -sz;
			3'sd1:  t = sz;
			3'sd2:  t = sz <<< 1;
			default: t = '0;
		endcase
		return t + T_W'(add);
	endfunction

	// breakpoint in map units to q.8
	function automatic coord_t bp_fix(bp_t b);
		coord_t r;
		r = COORD_W'(b);
		return r <<< FRAC_BITS;
	endfunction

endpackage

// ----- src/pwarp_if.sv -----
// ----------------------------------------------------------------------------
// pwarp_if
// valid/ready channels for source points and warped points
// ----------------------------------------------------------------------------
interface pwarp_in_if;
	import pwarp_pkg::*;

	logic   valid;
	logic   ready;
	coord_t in_x;
	coord_t in_y;
	coord_t in_z;

	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface pwarp_out_if;
	import pwarp_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   size_ok;

	modport source (output valid, out_x, out_y, out_z, size_ok, input ready);
	modport sink   (input valid, out_x, out_y, out_z, size_ok, output ready);
endinterface

// ----- src/pwarp_lane.sv -----
// ----------------------------------------------------------------------------
// pwarp_lane
// one axis of the warp: segment search, interpolation and saturation
// ----------------------------------------------------------------------------
module pwarp_lane (
	input  logic                 clk,
	input  pwarp_pkg::stage_en_t en,
	input  pwarp_pkg::axis_t     axis,
	input  logic                 kind,
	input  pwarp_pkg::size_t     size,
	input  pwarp_pkg::coord_t    v_in,
	output pwarp_pkg::coord_t    res
);
	import pwarp_pkg::*;

	// stage 1: input register and segment search
	coord_t v_s1;
	idx_t   n;
	idx_t   cnt;
	idx_t   e_idx;
	idx_t   lo_idx;
	idx_t   hi_idx;
	logic   is_edge;
	half_t  tgt [NUM_BP];
	sum_t   esum_c;
	coord_t d_full;
	half_t  dt_full;
	logic signed [SPAN_W-1:0] span_c;

	// stage 2
	logic              edge_s2;
	sum_t              esum_s2;
	logic [D_W-1:0]    d_s2;
	logic [DT_W-1:0]   dt_s2;
	half_t             base_s2;
	shift_t            shift_s2;
	recip_t            recip_s2;
	logic [HSPAN_W-1:0] hspan_s2;
	logic [PROD1_W-1:0] prod_c;
	logic [NUM_W-1:0]   num_c;

	// stage 3
	logic        edge_s3;
	sum_t        esum_s3;
	half_t       base_s3;
	recip_t      recip_s3;
	logic [X_W-1:0] x_s3;

	// stage 4
	logic           edge_s4;
	sum_t           esum_s4;
	half_t          base_s4;
	logic           pow2_s4;
	logic [X_W-1:0] x_s4;
	logic [PP_W-1:0] pp_hh_s4;
	logic [PP_W-1:0] pp_hl_s4;
	logic [PP_W-1:0] pp_lh_s4;
	logic [PP_W-1:0] pp_ll_s4;
	logic [FULL_W-1:0] full_c;

	// stage 5
	logic           edge_s5;
	sum_t           esum_s5;
	half_t          base_s5;
	logic [X_W-1:0] q_s5;
	sum_t           pre_c;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			v_s1 <= v_in;
		end
	end

	assign n = BP_COUNT[kind][axis];

	always_comb begin
		for (int i = 0; i < NUM_BP; i++) begin
			tgt[i] = tgt_half(TGT_MUL[kind][axis][i], TGT_ADD[kind][axis][i], size);
		end
	end

	// breakpoints rise, so the count of those at or below v picks the segment
	always_comb begin
		cnt = '0;
		for (int i = 0; i < NUM_BP; i++) begin
			if (idx_t'(i) < n && v_s1 >= bp_fix(SRC_BP[kind][axis][i])) begin
				cnt = idx_t'(i + 1);
			end
		end
	end

	assign is_edge = (cnt == '0) || (cnt == n);
	assign e_idx   = (cnt == '0) ? '0 : idx_t'(n - 3'd1);
	assign lo_idx  = is_edge ? '0 : idx_t'(cnt - 3'd1);
	assign hi_idx  = is_edge ? '0 : cnt;

	// outside the breakpoints the axis is only shifted
	assign esum_c = SUM_W'(v_s1) + (SUM_W'(tgt[e_idx]) <<< (FRAC_BITS - 1))
		- SUM_W'(bp_fix(SRC_BP[kind][axis][e_idx]));

	assign d_full  = v_s1 - bp_fix(SRC_BP[kind][axis][lo_idx]);
	assign dt_full = tgt[hi_idx] - tgt[lo_idx];
	assign span_c  = SPAN_W'(SRC_BP[kind][axis][hi_idx]) - SPAN_W'(SRC_BP[kind][axis][lo_idx]);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			edge_s2  <= is_edge;
			esum_s2  <= esum_c;
			d_s2     <= d_full[D_W-1:0];
			dt_s2    <= dt_full[DT_W-1:0];
			base_s2  <= tgt[lo_idx];
			shift_s2 <= SEG_SHIFT[kind][axis][hi_idx];
			recip_s2 <= SEG_RECIP[kind][axis][hi_idx];
			hspan_s2 <= span_c[HSPAN_W:1];
		end
	end

	// step times offset, plus half a span for rounding, then drop the power of two
	assign prod_c = PROD1_W'(dt_s2) * PROD1_W'(d_s2);
	assign num_c  = {prod_c, {(FRAC_BITS - 1){1'b0}}} + NUM_W'(hspan_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			edge_s3  <= edge_s2;
			esum_s3  <= esum_s2;
			base_s3  <= base_s2;
			recip_s3 <= recip_s2;
			x_s3     <= X_W'(num_c >> shift_s2);
		end
	end

	// divide by the odd part of the span: reciprocal product in four pieces
	always_ff @(posedge clk) begin
		if (en.s4) begin
			edge_s4  <= edge_s3;
			esum_s4  <= esum_s3;
			base_s4  <= base_s3;
			pow2_s4  <= (recip_s3 == '0);
			x_s4     <= x_s3;
			pp_hh_s4 <= PP_W'(x_s3[X_W-1:XL_W]) * PP_W'(recip_s3[RECIP_W-1:RL_W]);
			pp_hl_s4 <= PP_W'(x_s3[X_W-1:XL_W]) * PP_W'(recip_s3[RL_W-1:0]);
			pp_lh_s4 <= PP_W'(x_s3[XL_W-1:0]) * PP_W'(recip_s3[RECIP_W-1:RL_W]);
			pp_ll_s4 <= PP_W'(x_s3[XL_W-1:0]) * PP_W'(recip_s3[RL_W-1:0]);
		end
	end

	assign full_c = (FULL_W'(pp_hh_s4) << (XL_W + RL_W)) + (FULL_W'(pp_hl_s4) << XL_W)
		+ (FULL_W'(pp_lh_s4) << RL_W) + FULL_W'(pp_ll_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			edge_s5 <= edge_s4;
			esum_s5 <= esum_s4;
			base_s5 <= base_s4;
			q_s5    <= pow2_s4 ? x_s4 : X_W'(full_c >> RECIP_SH);
		end
	end

	assign pre_c = edge_s5 ? esum_s5
		: (SUM_W'(base_s5) <<< (FRAC_BITS - 1)) + $signed(SUM_W'(q_s5));

	always_comb begin
		if (pre_c > SAT_HI) begin
			res = SAT_HI[COORD_W-1:0];
		end else if (pre_c < SAT_LO) begin
			res = SAT_LO[COORD_W-1:0];
		end else begin
			res = pre_c[COORD_W-1:0];
		end
	end

endmodule

// ----- src/pwarp_merge.sv -----
// ----------------------------------------------------------------------------
// pwarp_merge
// joins the three lanes, applies the size check and holds the output register
// ----------------------------------------------------------------------------
module pwarp_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_s5,
	output logic                take,
	input  pwarp_pkg::coord_t   res_x,
	input  pwarp_pkg::coord_t   res_y,
	input  pwarp_pkg::coord_t   res_z,
	input  logic                kind,
	input  pwarp_pkg::size_t    size_x,
	input  pwarp_pkg::size_t    size_y,
	input  pwarp_pkg::size_z_t  size_z,
	pwarp_out_if.source         out_ch
);
	import pwarp_pkg::*;

	logic   ok;
	logic   out_vld_q;
	logic   size_ok_q;
	coord_t out_x_q;
	coord_t out_y_q;
	coord_t out_z_q;
	size_t  size_z_ext;

	assign size_z_ext = SIZE_W'(size_z);

	assign ok = (size_x >= SIZE_MIN[kind][AXIS_X]) && (size_x <= SIZE_MAX[kind][AXIS_X])
		&& (size_y >= SIZE_MIN[kind][AXIS_Y]) && (size_y <= SIZE_MAX[kind][AXIS_Y])
		&& (size_z_ext >= SIZE_MIN[kind][AXIS_Z]) && (size_z_ext <= SIZE_MAX[kind][AXIS_Z]);

	assign take = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (take && vld_s5) begin
			out_x_q   <= ok ? res_x : '0;
			out_y_q   <= ok ? res_y : '0;
			out_z_q   <= ok ? res_z : '0;
			size_ok_q <= ok;
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.out_x   = out_x_q;
	assign out_ch.out_y   = out_y_q;
	assign out_ch.out_z   = out_z_q;
	assign out_ch.size_ok = size_ok_q;

endmodule

// ----- src/piecewise_linear_point_warp_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_point_warp_core
// warps a q.8 point per axis through piecewise-linear breakpoint maps
// an accepted input passes lane stages s1 to s5 and then the output register
// throughput: one point per cycle; stalls only when the output is held and
//   every pipeline stage is full, five lane stages plus the output register
// reset: clears all stage valid bits and loads the default room configuration
// ----------------------------------------------------------------------------
module piecewise_linear_point_warp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pwarp_pkg::reg_idx_t cfg_idx,
	input  pwarp_pkg::size_t    cfg_data,
	pwarp_in_if.sink            in_ch,
	pwarp_out_if.source         out_ch
);
	import pwarp_pkg::*;

	// configuration registers
	logic    room_kind_q;
	size_t   size_x_q;
	size_t   size_y_q;
	size_z_t size_z_q;

	// stage valid bits and load enables
	logic      vld_s1;
	logic      vld_s2;
	logic      vld_s3;
	logic      vld_s4;
	logic      vld_s5;
	stage_en_t en;
	logic      take;

	coord_t res_x;
	coord_t res_y;
	coord_t res_z;

	// config writes must land only while idle; the block does not enforce it, and the lanes read them directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_kind_q <= RST_ROOM_KIND;
			size_x_q    <= RST_SIZE_X;
			size_y_q    <= RST_SIZE_Y;
			size_z_q    <= RST_SIZE_Z;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROOM_KIND: room_kind_q <= cfg_data[0];
				REG_SIZE_X:    size_x_q    <= cfg_data;
				REG_SIZE_Y:    size_y_q    <= cfg_data;
				REG_SIZE_Z:    size_z_q    <= cfg_data[SIZE_Z_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on; bubbles collapse
	assign en.s5 = !vld_s5 || take;
	assign en.s4 = !vld_s4 || en.s5;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;

	// input transaction is taken whenever the first stage can load
	assign in_ch.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.s1) begin
				vld_s1 <= in_ch.valid;
			end
			if (en.s2) begin
				vld_s2 <= vld_s1;
			end
			if (en.s3) begin
				vld_s3 <= vld_s2;
			end
			if (en.s4) begin
				vld_s4 <= vld_s3;
			end
			if (en.s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// one lane per axis, all sharing the stage enables
	pwarp_lane u_lane_x (
		.clk  (clk),
		.en   (en),
		.axis (AXIS_X),
		.kind (room_kind_q),
		.size (size_x_q),
		.v_in (in_ch.in_x),
		.res  (res_x)
	);

	pwarp_lane u_lane_y (
		.clk  (clk),
		.en   (en),
		.axis (AXIS_Y),
		.kind (room_kind_q),
		.size (size_y_q),
		.v_in (in_ch.in_y),
		.res  (res_y)
	);

	pwarp_lane u_lane_z (
		.clk  (clk),
		.en   (en),
		.axis (AXIS_Z),
		.kind (room_kind_q),
		.size (SIZE_W'(size_z_q)),
		.v_in (in_ch.in_z),
		.res  (res_z)
	);

	// size check, zeroing and the output register
	pwarp_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s5 (vld_s5),
		.take   (take),
		.res_x  (res_x),
		.res_y  (res_y),
		.res_z  (res_z),
		.kind   (room_kind_q),
		.size_x (size_x_q),
		.size_y (size_y_q),
		.size_z (size_z_q),
		.out_ch (out_ch)
	);

endmodule
